@@ rtl/lph_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash set package
// Shared constants, request codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int unsigned Slots      = 1024;
  localparam int unsigned SlotW      = $clog2(Slots);
  localparam int unsigned HashWords  = 128;
  localparam int unsigned HashW      = $clog2(HashWords);
  localparam int unsigned Digits     = 8;
  localparam int unsigned DigitBits  = 4;
  localparam int unsigned CountW     = 11;
  localparam int unsigned SizeW      = 4;
  localparam int unsigned MaxLog2    = $clog2(Slots);
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_LOAD   = 2'd3
  } req_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch a new request
    logic load_word;   // write a hash word
    logic hash_step;   // fold one digit into the hash
    logic probe_init;  // set probe position to the home slot
    logic rd_issue;    // read slot key and flags at probe position
    logic probe_next;  // advance probe position
    logic clear_step;  // clear one flag entry
    logic do_insert;   // place key at probe position
    logic do_delete;   // tombstone the probe position
    logic set_found;   // record a hit at probe position
    logic set_full;    // record a full table
    logic emit;        // present the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req;
    logic       hash_last;  // last digit being folded
    logic       slot_free;
    logic       slot_del;
    logic       key_eq;
    logic       probe_last; // all slots of the current size were probed
    logic       clear_last;
  } stat_t;

endpackage

@@ rtl/lph_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash set controller
// Sequences clearing, hash word loads, hashing, probing and the result strobe.
// ----------------------------------------------------------------------------
module lph_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  lph_pkg::stat_t stat_i,
  output lph_pkg::cmd_t  cmd_o
);
  import lph_pkg::*;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StHash  = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StEval  = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StClear: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = StHash;
        end
      end
      StHash: begin
        if (stat_i.req == REQ_LOAD) begin
          cmd_o.load_word = 1'b1;
          state_d = StDone;
        end else begin
          cmd_o.hash_step = 1'b1;
          if (stat_i.hash_last) begin
            cmd_o.probe_init = 1'b1;
            state_d = StRead;
          end
        end
      end
      StRead: begin
        cmd_o.rd_issue = 1'b1;
        state_d = StEval;
      end
      StEval: begin
        state_d = StDone;
        if (stat_i.req == REQ_INSERT) begin
          if (stat_i.slot_free || stat_i.slot_del) begin
            cmd_o.do_insert = 1'b1;
          end else if (stat_i.key_eq) begin
            cmd_o.set_found = 1'b1;
          end else if (stat_i.probe_last) begin
            cmd_o.set_full = 1'b1;
          end else begin
            cmd_o.probe_next = 1'b1;
            state_d = StRead;
          end
        end else begin
          if (stat_i.slot_free) begin
            state_d = StDone;
          end else if (!stat_i.slot_del && stat_i.key_eq) begin
            cmd_o.set_found = 1'b1;
            cmd_o.do_delete = (stat_i.req == REQ_DELETE);
          end else if (!stat_i.probe_last) begin
            cmd_o.probe_next = 1'b1;
            state_d = StRead;
          end
        end
      end
      StDone: begin
        cmd_o.emit = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

@@ rtl/lph_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash set datapath
// Hash word memory, slot memories, probe position, counters and result.
// ----------------------------------------------------------------------------
module lph_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lph_pkg::cmd_t                cmd_i,
  output lph_pkg::stat_t               stat_o,
  input  logic [1:0]                   req_type_i,
  input  logic [31:0]                  key_i,
  input  logic [lph_pkg::HashW-1:0]    word_index_i,
  input  logic [31:0]                  word_value_i,
  input  logic [lph_pkg::SizeW-1:0]    size_log2_i,
  output logic                         done_o,
  output logic                         found_o,
  output logic                         status_o,
  output logic [9:0]                   slot_index_o,
  output logic [lph_pkg::CountW-1:0]   active_count_o,
  output logic [lph_pkg::CountW-1:0]   used_count_o
);
  import lph_pkg::*;

  localparam int unsigned DigW = $clog2(Digits);
  localparam int unsigned CntW = SlotW + 1;

  logic [31:0] hash_mem [HashWords];
  logic [31:0] key_mem  [Slots];
  logic [1:0]  flag_mem [Slots]; // {deleted, used}

  logic [1:0]       req_q;
  logic [31:0]      key_q;
  logic [HashW-1:0] widx_q;
  logic [31:0]      wval_q;
  logic [DigW-1:0]  dig_q;
  logic [31:0]      hacc_q;
  logic [31:0]      hword_q;
  logic             hvalid_q;
  logic [SlotW-1:0] pos_q;
  logic [CntW-1:0]  pcnt_q;
  logic [SlotW-1:0] mask_q;
  logic [31:0]      rkey_q;
  logic [1:0]       rflag_q;
  logic [SlotW-1:0] clr_q;
  logic             found_q, status_q, done_q;
  logic [9:0]       slot_q;
  logic [CountW-1:0] live_q, occ_q;

  // Slot mask for the current size, limited to the store depth.
  logic [SizeW-1:0] lg;
  logic [SlotW-1:0] mask_w;
  always_comb begin
    lg = size_log2_i;
    if (lg == '0) lg = SizeW'(1);
    if (lg > SizeW'(MaxLog2)) lg = SizeW'(MaxLog2);
    mask_w = SlotW'((CntW'(1) << lg) - CntW'(1));
  end

  logic [HashW-1:0] haddr;
  logic [31:0]      hnext;
  assign haddr = {dig_q, key_q[DigitBits*dig_q +: DigitBits]};
  assign hnext = hvalid_q ? (hacc_q ^ hword_q) : hacc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_word) hash_mem[widx_q] <= wval_q;
    hword_q <= hash_mem[haddr];
  end

  // Hash: one digit read per cycle, the word folded in the next.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_q    <= '0;
      hvalid_q <= 1'b0;
    end else if (cmd_i.capture) begin
      dig_q    <= '0;
      hvalid_q <= 1'b0;
    end else if (cmd_i.hash_step) begin
      dig_q    <= dig_q + DigW'(1);
      hvalid_q <= 1'b1;
    end
  end

  logic hash_pad_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hash_pad_q <= 1'b0;
    else if (cmd_i.capture) hash_pad_q <= 1'b0;
    else if (cmd_i.hash_step && dig_q == DigW'(Digits-1)) hash_pad_q <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      key_q  <= key_i;
      widx_q <= word_index_i;
      wval_q <= word_value_i;
      hacc_q <= '0;
      mask_q <= mask_w;
    end else if (cmd_i.hash_step) begin
      hacc_q <= hnext;
    end
  end

  // Probe position; home slot comes from the final fold.
  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_init) begin
      pos_q  <= SlotW'(hnext) & mask_q;
      pcnt_q <= CntW'(1);
    end else if (cmd_i.probe_next) begin
      pos_q  <= (pos_q + SlotW'(1)) & mask_q;
      pcnt_q <= pcnt_q + CntW'(1);
    end
  end

  // Slot stores.
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_insert) key_mem[pos_q] <= key_q;
    if (cmd_i.rd_issue) rkey_q <= key_mem[pos_q];
  end

  logic [SlotW-1:0] faddr;
  logic [1:0]       fdata;
  logic             fwe;
  always_comb begin
    faddr = pos_q;
    fdata = 2'b01;
    fwe   = cmd_i.do_insert;
    if (cmd_i.clear_step) begin
      faddr = clr_q;
      fdata = 2'b00;
      fwe   = 1'b1;
    end else if (cmd_i.do_delete) begin
      fdata = 2'b11;
      fwe   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fwe) flag_mem[faddr] <= fdata;
    if (cmd_i.rd_issue) rflag_q <= flag_mem[pos_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clear_step) clr_q <= clr_q + SlotW'(1);
  end

  // Counters and result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q   <= '0;
      occ_q    <= '0;
      found_q  <= 1'b0;
      status_q <= 1'b0;
      slot_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cmd_i.capture) begin
        found_q  <= 1'b0;
        status_q <= 1'b0;
        slot_q   <= '0;
      end
      if (cmd_i.do_insert) begin
        slot_q <= 10'(pos_q);
        if (live_q != CountMax) live_q <= live_q + CountW'(1);
        if (!rflag_q[0] && occ_q != CountMax) occ_q <= occ_q + CountW'(1);
      end
      if (cmd_i.set_found) begin
        found_q <= 1'b1;
        slot_q  <= 10'(pos_q);
      end
      if (cmd_i.do_delete && live_q != '0) live_q <= live_q - CountW'(1);
      if (cmd_i.set_full) status_q <= 1'b1;
    end
  end

  always_comb begin
    stat_o.req        = req_q;
    stat_o.hash_last  = hash_pad_q;
    stat_o.slot_free  = !rflag_q[0];
    stat_o.slot_del   = rflag_q[1];
    stat_o.key_eq     = (rkey_q == key_q);
    stat_o.probe_last = (pcnt_q == CntW'({1'b0, mask_q}) + CntW'(1));
    stat_o.clear_last = (clr_q == SlotW'(Slots-1));
  end

  assign done_o         = done_q;
  assign found_o        = found_q;
  assign status_o       = status_q;
  assign slot_index_o   = slot_q;
  assign active_count_o = live_q;
  assign used_count_o   = occ_q;

endmodule

@@ rtl/linear_probe_hash_set.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash set
// Set of 32-bit keys, linear probing with tombstones, tabulation hash.
// ----------------------------------------------------------------------------
// A request is accepted at a clock edge where start is high and busy is
// low. req_type_i selects insert, lookup, delete or a hash word load. Every
// request gives exactly one result item, shown for one cycle with done_o high;
// the receiver cannot stall, so the result must be taken in that cycle.
// A load writes its hash word, then shows its result. A key request folds
// the eight table digits one per cycle through the single hash word memory
// port, then probes slots one at a time through the slot memory read port,
// each probe taking a read state and an evaluate state. One request is in
// work at a time; busy drops in the cycle the result is shown, so the next
// request can be accepted at the edge that takes the result.
// After reset the slot flag memory is swept, one entry per cycle, over all
// 1024 entries with busy high; configuration writes are taken at any time.
// size_log2 is written through cfg_valid_i/cfg_ready_o and should change only
// while the block is idle. Hash words must be loaded before keys are used.
// ----------------------------------------------------------------------------
module linear_probe_hash_set (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type_i,
  input  logic [31:0]                 key_i,
  input  logic [6:0]                  word_index_i,
  input  logic [31:0]                 word_value_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lph_pkg::SizeW-1:0]   cfg_data_i,
  output logic                        done_o,
  output logic                        found_o,
  output logic                        status_o,
  output logic [9:0]                  slot_index_o,
  output logic [10:0]                 active_count_o,
  output logic [10:0]                 used_count_o
);
  import lph_pkg::*;

  cmd_t             cmd;
  stat_t            stat;
  logic [SizeW-1:0] size_log2_q;

  // The size register is always ready to take a write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= SizeW'(10);
    end else if (cfg_valid_i) begin
      size_log2_q <= cfg_data_i;
    end
  end

  lph_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  lph_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .req_type_i    (req_type_i),
    .key_i         (key_i),
    .word_index_i  (word_index_i),
    .word_value_i  (word_value_i),
    .size_log2_i   (size_log2_q),
    .done_o        (done_o),
    .found_o       (found_o),
    .status_o      (status_o),
    .slot_index_o  (slot_index_o),
    .active_count_o(active_count_o),
    .used_count_o  (used_count_o)
  );

endmodule
